FILE: rtl/core/stt_pkg.sv
// Shared types, token codes, character classes and the keyword table of the
// source text tokenizer. No dependencies.
package stt_pkg;

   localparam int KIND_W     = 7;
   localparam int LEN_W      = 21;
   localparam int KW_COUNT   = 39;
   localparam int KW_MAX     = 8;
   localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

   typedef logic [KIND_W-1:0] kind_type;

   typedef enum logic [18:0] {
      S_IDLE    = 19'h00001,
      S_IDENT   = 19'h00002,
      S_NUM0    = 19'h00004,
      S_NUMD    = 19'h00008,
      S_HEX     = 19'h00010,
      S_BIN     = 19'h00020,
      S_STR     = 19'h00040,
      S_STRESC  = 19'h00080,
      S_CHOPEN  = 19'h00100,
      S_CHESC   = 19'h00200,
      S_CHCLOSE = 19'h00400,
      S_SL1     = 19'h00800,
      S_SL2     = 19'h01000,
      S_LINE    = 19'h02000,
      S_BLK0    = 19'h04000,
      S_BLK1    = 19'h08000,
      S_BLK2    = 19'h10000,
      S_OPER    = 19'h20000,
      S_DEAD    = 19'h40000
   } mode_type;

   localparam kind_type K_END = 7'd0, K_IDENT = 7'd1, K_NUMBER = 7'd2, K_DECIMAL = 7'd3,
      K_STRING = 7'd4, K_STRBYTE = 7'd5, K_CHARLIT = 7'd6, K_KW0 = 7'd7, K_NOT = 7'd45,
      K_SHL_ASG = 7'd46, K_SHR_ASG = 7'd47, K_SCOPE = 7'd48, K_EQ = 7'd49, K_NE = 7'd50,
      K_LE = 7'd51, K_GE = 7'd52, K_INC = 7'd53, K_DECR = 7'd54, K_LAND = 7'd55,
      K_LOR = 7'd56, K_SHL = 7'd57, K_SHR = 7'd58, K_ADD_ASG = 7'd59, K_ARROW = 7'd60,
      K_SUB_ASG = 7'd61, K_MUL_ASG = 7'd62, K_DIV_ASG = 7'd63, K_MOD_ASG = 7'd64,
      K_AND_ASG = 7'd65, K_OR_ASG = 7'd66, K_XOR_ASG = 7'd67, K_ADD = 7'd68,
      K_SUB = 7'd69, K_MUL = 7'd70, K_DIV = 7'd71, K_MOD = 7'd72, K_ASG = 7'd73,
      K_LT = 7'd74, K_GT = 7'd75, K_AND = 7'd76, K_OR = 7'd77, K_XOR = 7'd78,
      K_TILDE = 7'd79, K_QUEST = 7'd80, K_LPAR = 7'd81, K_RPAR = 7'd82,
      K_LBRK = 7'd83, K_RBRK = 7'd84, K_LBRC = 7'd85, K_RBRC = 7'd86,
      K_SEMI = 7'd87, K_COLON = 7'd88, K_COMMA = 7'd89, K_DOT = 7'd90, K_AT = 7'd91,
      K_ERR_CHAR = 7'd92, K_ERR_STR_OPEN = 7'd93, K_ERR_STR_LONG = 7'd94,
      K_ERR_CHR_OPEN = 7'd95, K_ERR_CMT_OPEN = 7'd96, K_NONE = 7'd127;

   localparam logic [7:0] CH_NL = 8'h0A, CH_DQUOTE = 8'h22, CH_SQUOTE = 8'h27,
      CH_BSLASH = 8'h5C, CH_SLASH = 8'h2F, CH_LT = 8'h3C, CH_GT = 8'h3E,
      CH_EQ = 8'h3D, CH_DOT = 8'h2E, CH_USCORE = 8'h5F;

   // keyword text is right-justified: first character in the highest used byte
   localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
      64'("fnc"), 64'("get"), 64'("loop"), 64'("if"), 64'("or"), 64'("else"),
      64'("while"), 64'("cycle"), 64'("when"), 64'("fixed"), 64'("check"),
      64'("read"), 64'("show"), 64'("showf"), 64'("group"), 64'("set"), 64'("arr"),
      64'("map"), 64'("pkg"), 64'("use"), 64'("const"), 64'("break"),
      64'("continue"), 64'("defer"), 64'("emit"), 64'("manme"), 64'("int"),
      64'("deci"), 64'("char"), 64'("str"), 64'("bool"), 64'("byte"), 64'("ubyte"),
      64'("none"), 64'("true"), 64'("false"), 64'("and"), 64'("xor"), 64'("not")};

   localparam logic [3:0] KW_LEN [KW_COUNT] = '{
      4'd3, 4'd3, 4'd4, 4'd2, 4'd2, 4'd4, 4'd5, 4'd5, 4'd4, 4'd5, 4'd5, 4'd4, 4'd4,
      4'd5, 4'd5, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd5, 4'd5, 4'd8, 4'd5, 4'd4, 4'd5,
      4'd3, 4'd4, 4'd4, 4'd3, 4'd4, 4'd4, 4'd5, 4'd4, 4'd4, 4'd5, 4'd3, 4'd3, 4'd3};

   function automatic logic is_space(input logic [7:0] b);
      return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return b >= 8'h30 && b <= 8'h39;
   endfunction

   function automatic logic is_alpha(input logic [7:0] b);
      return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
   endfunction

   function automatic logic is_xdigit(input logic [7:0] b);
      return is_digit(b) || (b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46);
   endfunction

   function automatic logic [7:0] decode_esc(input logic [7:0] b);
      logic [7:0] r;
      case (b)
         8'h6E:   r = 8'h0A;
         8'h74:   r = 8'h09;
         8'h72:   r = 8'h0D;
         8'h62:   r = 8'h08;
         8'h76:   r = 8'h0B;
         8'h66:   r = 8'h0C;
         8'h61:   r = 8'h07;
         default: r = b;
      endcase
      return r;
   endfunction

   function automatic logic is_op_lead(input logic [7:0] c);
      return c inside {8'h3C, 8'h3E, 8'h3A, 8'h3D, 8'h21, 8'h2B, 8'h2D, 8'h26,
                       8'h7C, 8'h2A, 8'h25, 8'h5E};
   endfunction

   function automatic kind_type single_kind(input logic [7:0] c);
      kind_type k;
      case (c)
         8'h2B:   k = K_ADD;
         8'h2D:   k = K_SUB;
         8'h2A:   k = K_MUL;
         8'h2F:   k = K_DIV;
         8'h25:   k = K_MOD;
         8'h3D:   k = K_ASG;
         8'h3C:   k = K_LT;
         8'h3E:   k = K_GT;
         8'h21:   k = K_NOT;
         8'h26:   k = K_AND;
         8'h7C:   k = K_OR;
         8'h5E:   k = K_XOR;
         8'h7E:   k = K_TILDE;
         8'h3F:   k = K_QUEST;
         8'h28:   k = K_LPAR;
         8'h29:   k = K_RPAR;
         8'h5B:   k = K_LBRK;
         8'h5D:   k = K_RBRK;
         8'h7B:   k = K_LBRC;
         8'h7D:   k = K_RBRC;
         8'h3B:   k = K_SEMI;
         8'h3A:   k = K_COLON;
         8'h2C:   k = K_COMMA;
         8'h2E:   k = K_DOT;
         8'h40:   k = K_AT;
         default: k = K_NONE;
      endcase
      return k;
   endfunction

   function automatic kind_type pair_kind(input logic [7:0] c, input logic [7:0] x);
      kind_type k;
      logic x_eq;
      x_eq = (x == CH_EQ);
      k = K_NONE;
      case (c)
         8'h3C:   k = (x == CH_LT) ? K_SHL : x_eq ? K_LE : K_NONE;
         8'h3E:   k = (x == CH_GT) ? K_SHR : x_eq ? K_GE : K_NONE;
         8'h3A:   k = (x == 8'h3A) ? K_SCOPE : K_NONE;
         8'h3D:   k = x_eq ? K_EQ : K_NONE;
         8'h21:   k = x_eq ? K_NE : K_NONE;
         8'h2B:   k = (x == 8'h2B) ? K_INC : x_eq ? K_ADD_ASG : K_NONE;
         8'h2D:   k = (x == 8'h2D) ? K_DECR : (x == CH_GT) ? K_ARROW :
                      x_eq ? K_SUB_ASG : K_NONE;
         8'h26:   k = (x == 8'h26) ? K_LAND : x_eq ? K_AND_ASG : K_NONE;
         8'h7C:   k = (x == 8'h7C) ? K_LOR : x_eq ? K_OR_ASG : K_NONE;
         8'h2A:   k = x_eq ? K_MUL_ASG : K_NONE;
         8'h25:   k = x_eq ? K_MOD_ASG : K_NONE;
         8'h5E:   k = x_eq ? K_XOR_ASG : K_NONE;
         default: k = K_NONE;
      endcase
      return k;
   endfunction

endpackage

FILE: rtl/core/source_text_tokenizer_unit.sv
// Top level of the source text tokenizer: scanner state, one-pass token logic
// and the result queue. Depends on stt_pkg, stt_kw_match and stt_outq.
//
//   channel | direction | payload
//   req_    | in        | char_byte, end_of_source
//   rsp_    | out       | token_kind, first_line, start_column, text_length, value_byte, last_of_run
//
// Each request is scanned in the cycle it is accepted; one request per cycle while req_ready is high.
// A request yields zero, one or two results; results leave a two-entry queue one per cycle while
// rsp_ready is high, so a request that yields two results stalls the next request.
// req_ready is high while the queue will be empty after this cycle's pop.
// Reset is synchronous and returns the scanner to line 1, column 1.
module source_text_tokenizer_unit #(
   parameter int KEYWORD_CHARS = 8,
   parameter int POSITION_BITS = 16,
   parameter int STRING_LIMIT  = 1048576
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [7:0]               req_char_byte,
   input  logic                     req_end_of_source,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [6:0]               rsp_token_kind,
   output logic [POSITION_BITS-1:0] rsp_first_line,
   output logic [POSITION_BITS-1:0] rsp_start_column,
   output logic [20:0]              rsp_text_length,
   output logic [7:0]               rsp_value_byte,
   output logic                     rsp_last_of_run
);

   localparam int PB    = POSITION_BITS;
   localparam int WL_W  = $clog2(KEYWORD_CHARS + 2);
   localparam int DC_W  = $clog2(STRING_LIMIT + 1);
   localparam int RES_W = stt_pkg::KIND_W + 2 * PB + stt_pkg::LEN_W + 8 + 1;
   localparam logic [PB-1:0] POS_MAX = {PB{1'b1}};
   localparam logic [PB-1:0] POS_ONE = PB'(1);

   stt_pkg::mode_type mode_ff, mode_in;
   logic [7:0]              pend_ff, pend_in;
   logic                    pend2_ff, pend2_in;
   logic [7:0]              wbuf_ff [KEYWORD_CHARS];
   logic [7:0]              wbuf_in [KEYWORD_CHARS];
   logic [WL_W-1:0]         wlen_ff, wlen_in;
   logic [PB-1:0]           line_ff, line_in, col_ff, col_in;
   logic [PB-1:0]           tline_ff, tline_in, tcol_ff, tcol_in;
   logic [stt_pkg::LEN_W-1:0] tbytes_ff, tbytes_in;
   logic                    dot_ff, dot_in;
   logic [DC_W-1:0]         dcnt_ff, dcnt_in;
   logic [7:0]              held_ff, held_in;

   logic                    a_v, b_v;
   stt_pkg::kind_type       a_kind, b_kind, kw_kind, pk, sk;
   logic [PB-1:0]           a_line, a_col, b_line, b_col;
   logic [stt_pkg::LEN_W-1:0] a_len, b_len;
   logic [7:0]              a_val, b_val, b;
   logic                    restart, fire;
   logic [1:0]              q_count;
   logic [RES_W-1:0]        q_head;

   stt_kw_match #(.KEYWORD_CHARS(KEYWORD_CHARS), .WL_W(WL_W)) u_kw (
      .word     (wbuf_ff),
      .word_len (wlen_ff),
      .kind     (kw_kind)
   );

   assign fire      = req_valid && req_ready;
   assign b         = req_char_byte;
   assign pk        = stt_pkg::pair_kind(pend_ff, b);
   assign sk        = stt_pkg::single_kind(b);
   assign rsp_valid = (q_count != 2'd0);
   assign req_ready = (q_count == 2'd0) || (q_count == 2'd1 && rsp_ready);

   always_comb begin
      mode_in   = mode_ff;
      pend_in   = pend_ff;
      pend2_in  = pend2_ff;
      wbuf_in   = wbuf_ff;
      wlen_in   = wlen_ff;
      line_in   = line_ff;
      col_in    = col_ff;
      tline_in  = tline_ff;
      tcol_in   = tcol_ff;
      tbytes_in = tbytes_ff;
      dot_in    = dot_ff;
      dcnt_in   = dcnt_ff;
      held_in   = held_ff;
      restart   = 1'b0;
      a_v = 1'b0; a_kind = stt_pkg::K_END; a_val = '0;
      a_line = tline_ff; a_col = tcol_ff; a_len = tbytes_ff;
      b_v = 1'b0; b_kind = stt_pkg::K_END; b_val = '0;
      b_line = tline_ff; b_col = tcol_ff; b_len = tbytes_ff;

      if (req_end_of_source) begin
         // flush the open token, then the end marker
         case (mode_ff)
            stt_pkg::S_IDENT: begin
               a_v = 1'b1; a_kind = kw_kind;
            end
            stt_pkg::S_NUM0, stt_pkg::S_NUMD, stt_pkg::S_HEX, stt_pkg::S_BIN: begin
               a_v = 1'b1; a_kind = dot_ff ? stt_pkg::K_DECIMAL : stt_pkg::K_NUMBER;
            end
            stt_pkg::S_STR, stt_pkg::S_STRESC: begin
               a_v = 1'b1; a_kind = stt_pkg::K_ERR_STR_OPEN;
            end
            stt_pkg::S_CHOPEN, stt_pkg::S_CHESC, stt_pkg::S_CHCLOSE: begin
               a_v = 1'b1; a_kind = stt_pkg::K_ERR_CHR_OPEN;
            end
            stt_pkg::S_SL1: begin
               a_v = 1'b1; a_kind = stt_pkg::K_DIV;
            end
            stt_pkg::S_BLK0, stt_pkg::S_BLK1, stt_pkg::S_BLK2: begin
               a_v = 1'b1; a_kind = stt_pkg::K_ERR_CMT_OPEN;
               a_line = line_ff; a_col = col_ff;
            end
            stt_pkg::S_OPER: begin
               a_v = 1'b1;
               a_kind = pend2_ff ? ((pend_ff == stt_pkg::CH_LT) ? stt_pkg::K_SHL
                                                                : stt_pkg::K_SHR)
                                 : stt_pkg::single_kind(pend_ff);
            end
            default: ;
         endcase
         b_v = 1'b1; b_kind = stt_pkg::K_END;
         b_line = line_ff; b_col = col_ff; b_len = '0;
         mode_in = stt_pkg::S_IDLE; pend_in = '0; pend2_in = 1'b0; wlen_in = '0;
         line_in = POS_ONE; col_in = POS_ONE; tline_in = POS_ONE; tcol_in = POS_ONE;
         tbytes_in = '0; dot_in = 1'b0; dcnt_in = '0; held_in = '0;
      end else begin
         // continue the open token; a byte that ends it restarts in idle
         case (mode_ff)
            stt_pkg::S_IDLE: restart = 1'b1;
            stt_pkg::S_IDENT: begin
               if (stt_pkg::is_alpha(b) || stt_pkg::is_digit(b) || b == stt_pkg::CH_USCORE)
               begin
                  for (int j = 0; j < KEYWORD_CHARS; j++) begin
                     if (wlen_ff == WL_W'(j)) wbuf_in[j] = b;
                  end
                  if (wlen_ff <= WL_W'(KEYWORD_CHARS)) wlen_in = wlen_ff + WL_W'(1);
                  if (tbytes_in != stt_pkg::LEN_MAX) tbytes_in = tbytes_in + 1'b1;
               end else begin
                  a_v = 1'b1; a_kind = kw_kind; restart = 1'b1;
               end
            end
            stt_pkg::S_NUM0, stt_pkg::S_NUMD: begin
               if (mode_ff == stt_pkg::S_NUM0 && (b == 8'h78 || b == 8'h58)) begin
                  if (tbytes_in != stt_pkg::LEN_MAX) tbytes_in = tbytes_in + 1'b1;
                  mode_in = stt_pkg::S_HEX;
               end else if (mode_ff == stt_pkg::S_NUM0 && (b == 8'h62 || b == 8'h42)) begin
                  if (tbytes_in != stt_pkg::LEN_MAX) tbytes_in = tbytes_in + 1'b1;
                  mode_in = stt_pkg::S_BIN;
               end else if (stt_pkg::is_digit(b) || (b == stt_pkg::CH_DOT && !dot_ff)) begin
                  if (b == stt_pkg::CH_DOT) dot_in = 1'b1;
                  if (tbytes_in != stt_pkg::LEN_MAX) tbytes_in = tbytes_in + 1'b1;
                  mode_in = stt_pkg::S_NUMD;
               end else begin
                  a_v = 1'b1; restart = 1'b1;
                  a_kind = dot_ff ? stt_pkg::K_DECIMAL : stt_pkg::K_NUMBER;
               end
            end
            stt_pkg::S_HEX, stt_pkg::S_BIN: begin
               if ((mode_ff == stt_pkg::S_HEX && stt_pkg::is_xdigit(b)) ||
                   (mode_ff == stt_pkg::S_BIN && (b == 8'h30 || b == 8'h31))) begin
                  if (tbytes_in != stt_pkg::LEN_MAX) tbytes_in = tbytes_in + 1'b1;
               end else begin
                  a_v = 1'b1; restart = 1'b1;
                  a_kind = dot_ff ? stt_pkg::K_DECIMAL : stt_pkg::K_NUMBER;
               end
            end
            stt_pkg::S_STR: begin
               if (tbytes_in != stt_pkg::LEN_MAX) tbytes_in = tbytes_in + 1'b1;
               if (b == stt_pkg::CH_DQUOTE) begin
                  a_v = 1'b1; a_kind = stt_pkg::K_STRING; a_len = tbytes_in;
                  mode_in = stt_pkg::S_IDLE;
               end else if (dcnt_ff >= DC_W'(STRING_LIMIT)) begin
                  a_v = 1'b1; a_kind = stt_pkg::K_ERR_STR_LONG; a_len = tbytes_in;
                  mode_in = stt_pkg::S_DEAD;
               end else if (b == stt_pkg::CH_BSLASH) begin
                  mode_in = stt_pkg::S_STRESC;
               end else begin
                  dcnt_in = dcnt_ff + DC_W'(1);
                  a_v = 1'b1; a_kind = stt_pkg::K_STRBYTE;
                  a_len = stt_pkg::LEN_W'(1); a_val = b;
               end
            end
            stt_pkg::S_STRESC: begin
               if (tbytes_in != stt_pkg::LEN_MAX) tbytes_in = tbytes_in + 1'b1;
               dcnt_in = dcnt_ff + DC_W'(1);
               a_v = 1'b1; a_kind = stt_pkg::K_STRBYTE;
               a_len = stt_pkg::LEN_W'(2); a_val = stt_pkg::decode_esc(b);
               mode_in = stt_pkg::S_STR;
            end
            stt_pkg::S_CHOPEN: begin
               if (tbytes_in != stt_pkg::LEN_MAX) tbytes_in = tbytes_in + 1'b1;
               if (b == stt_pkg::CH_BSLASH) begin
                  mode_in = stt_pkg::S_CHESC;
               end else begin
                  held_in = b; mode_in = stt_pkg::S_CHCLOSE;
               end
            end
            stt_pkg::S_CHESC: begin
               if (tbytes_in != stt_pkg::LEN_MAX) tbytes_in = tbytes_in + 1'b1;
               held_in = stt_pkg::decode_esc(b);
               mode_in = stt_pkg::S_CHCLOSE;
            end
            stt_pkg::S_CHCLOSE: begin
               a_v = 1'b1;
               if (b == stt_pkg::CH_SQUOTE) begin
                  a_kind = stt_pkg::K_CHARLIT; a_val = held_ff;
                  if (tbytes_in != stt_pkg::LEN_MAX) tbytes_in = tbytes_in + 1'b1;
                  a_len = tbytes_in;
                  mode_in = stt_pkg::S_IDLE;
               end else begin
                  // missing close quote: report with the length so far, swallow b
                  a_kind = stt_pkg::K_ERR_CHR_OPEN;
                  if (tbytes_in != stt_pkg::LEN_MAX) tbytes_in = tbytes_in + 1'b1;
                  mode_in = stt_pkg::S_DEAD;
               end
            end
            stt_pkg::S_SL1: begin
               if (b == stt_pkg::CH_SLASH) begin
                  if (tbytes_in != stt_pkg::LEN_MAX) tbytes_in = tbytes_in + 1'b1;
                  mode_in = stt_pkg::S_SL2;
               end else if (b == stt_pkg::CH_EQ) begin
                  if (tbytes_in != stt_pkg::LEN_MAX) tbytes_in = tbytes_in + 1'b1;
                  a_v = 1'b1; a_kind = stt_pkg::K_DIV_ASG; a_len = tbytes_in;
                  mode_in = stt_pkg::S_IDLE;
               end else begin
                  a_v = 1'b1; a_kind = stt_pkg::K_DIV; restart = 1'b1;
               end
            end
            stt_pkg::S_SL2, stt_pkg::S_LINE: begin
               if (mode_ff == stt_pkg::S_SL2 && b == stt_pkg::CH_GT) begin
                  if (tbytes_in != stt_pkg::LEN_MAX) tbytes_in = tbytes_in + 1'b1;
                  mode_in = stt_pkg::S_BLK0;
               end else if (b == stt_pkg::CH_NL) begin
                  restart = 1'b1;
               end else begin
                  if (tbytes_in != stt_pkg::LEN_MAX) tbytes_in = tbytes_in + 1'b1;
                  mode_in = stt_pkg::S_LINE;
               end
            end
            stt_pkg::S_BLK0, stt_pkg::S_BLK1, stt_pkg::S_BLK2: begin
               if (tbytes_in != stt_pkg::LEN_MAX) tbytes_in = tbytes_in + 1'b1;
               if (b == stt_pkg::CH_LT) mode_in = stt_pkg::S_BLK1;
               else if (b == stt_pkg::CH_SLASH && mode_ff == stt_pkg::S_BLK1)
                  mode_in = stt_pkg::S_BLK2;
               else if (b == stt_pkg::CH_SLASH && mode_ff == stt_pkg::S_BLK2)
                  mode_in = stt_pkg::S_IDLE;
               else mode_in = stt_pkg::S_BLK0;
            end
            stt_pkg::S_OPER: begin
               if (pend2_ff) begin
                  a_v = 1'b1;
                  if (b == stt_pkg::CH_EQ) begin
                     if (tbytes_in != stt_pkg::LEN_MAX) tbytes_in = tbytes_in + 1'b1;
                     a_len  = tbytes_in;
                     a_kind = (pend_ff == stt_pkg::CH_LT) ? stt_pkg::K_SHL_ASG
                                                           : stt_pkg::K_SHR_ASG;
                     mode_in = stt_pkg::S_IDLE;
                  end else begin
                     a_kind = (pend_ff == stt_pkg::CH_LT) ? stt_pkg::K_SHL : stt_pkg::K_SHR;
                     restart = 1'b1;
                  end
               end else if (pk == stt_pkg::K_NONE) begin
                  a_v = 1'b1; a_kind = stt_pkg::single_kind(pend_ff); restart = 1'b1;
               end else begin
                  if (tbytes_in != stt_pkg::LEN_MAX) tbytes_in = tbytes_in + 1'b1;
                  if (pk == stt_pkg::K_SHL || pk == stt_pkg::K_SHR) begin
                     // hold for a possible trailing '='
                     pend2_in = 1'b1;
                  end else begin
                     a_v = 1'b1; a_kind = pk; a_len = tbytes_in;
                     mode_in = stt_pkg::S_IDLE;
                  end
               end
            end
            stt_pkg::S_DEAD: ;
            default: restart = 1'b1;
         endcase

         if (restart) begin
            mode_in = stt_pkg::S_IDLE;
            if (!stt_pkg::is_space(b)) begin
               tline_in = line_ff; tcol_in = col_ff;
               tbytes_in = stt_pkg::LEN_W'(1);
               dot_in = 1'b0; wlen_in = '0; dcnt_in = '0; pend2_in = 1'b0;
               if (stt_pkg::is_digit(b)) begin
                  mode_in = (b == 8'h30) ? stt_pkg::S_NUM0 : stt_pkg::S_NUMD;
               end else if (b == stt_pkg::CH_DQUOTE) begin
                  mode_in = stt_pkg::S_STR;
               end else if (b == stt_pkg::CH_SQUOTE) begin
                  mode_in = stt_pkg::S_CHOPEN;
               end else if (stt_pkg::is_alpha(b) || b == stt_pkg::CH_USCORE) begin
                  wbuf_in[0] = b; wlen_in = WL_W'(1);
                  mode_in = stt_pkg::S_IDENT;
               end else if (b == stt_pkg::CH_SLASH) begin
                  mode_in = stt_pkg::S_SL1;
               end else if (stt_pkg::is_op_lead(b)) begin
                  pend_in = b; mode_in = stt_pkg::S_OPER;
               end else begin
                  b_v = 1'b1; b_line = line_ff; b_col = col_ff;
                  b_len = stt_pkg::LEN_W'(1);
                  if (sk == stt_pkg::K_NONE) begin
                     b_kind = stt_pkg::K_ERR_CHAR; b_val = b;
                  end else begin
                     b_kind = sk;
                  end
               end
            end
         end

         // every byte moves the source position, which saturates at its maximum
         if (b == stt_pkg::CH_NL) begin
            if (line_ff != POS_MAX) line_in = line_ff + POS_ONE;
            col_in = POS_ONE;
         end else if (col_ff != POS_MAX) begin
            col_in = col_ff + POS_ONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= stt_pkg::S_IDLE;
         pend_ff   <= '0;
         pend2_ff  <= 1'b0;
         wlen_ff   <= '0;
         line_ff   <= POS_ONE;
         col_ff    <= POS_ONE;
         tline_ff  <= POS_ONE;
         tcol_ff   <= POS_ONE;
         tbytes_ff <= '0;
         dot_ff    <= 1'b0;
         dcnt_ff   <= '0;
         held_ff   <= '0;
      end else if (fire) begin
         mode_ff   <= mode_in;
         pend_ff   <= pend_in;
         pend2_ff  <= pend2_in;
         wlen_ff   <= wlen_in;
         line_ff   <= line_in;
         col_ff    <= col_in;
         tline_ff  <= tline_in;
         tcol_ff   <= tcol_in;
         tbytes_ff <= tbytes_in;
         dot_ff    <= dot_in;
         dcnt_ff   <= dcnt_in;
         held_ff   <= held_in;
      end
      if (fire) begin
         wbuf_ff <= wbuf_in;
      end
   end

   stt_outq #(.WIDTH(RES_W)) u_outq (
      .clock  (clock),
      .reset  (reset),
      .push_a (fire && a_v),
      .data_a ({a_kind, a_line, a_col, a_len, a_val, !b_v}),
      .push_b (fire && b_v),
      .data_b ({b_kind, b_line, b_col, b_len, b_val, 1'b1}),
      .pop    (rsp_valid && rsp_ready),
      .count  (q_count),
      .head   (q_head)
   );

   assign {rsp_token_kind, rsp_first_line, rsp_start_column, rsp_text_length,
           rsp_value_byte, rsp_last_of_run} = q_head;

endmodule

FILE: rtl/core/stt_kw_match.sv
// Keyword lookup: parallel compare of the word buffer against every keyword.
// Depends on stt_pkg.
module stt_kw_match #(
   parameter int KEYWORD_CHARS = 8,
   parameter int WL_W          = $clog2(KEYWORD_CHARS + 2)
) (
   input  logic [7:0]       word    [KEYWORD_CHARS],
   input  logic [WL_W-1:0]  word_len,
   output stt_pkg::kind_type kind
);

   logic [stt_pkg::KW_COUNT-1:0] hit;

   always_comb begin
      for (int i = 0; i < stt_pkg::KW_COUNT; i++) begin
         hit[i] = (word_len == WL_W'(stt_pkg::KW_LEN[i]));
         for (int j = 0; j < stt_pkg::KW_MAX; j++) begin
            if (j < int'(stt_pkg::KW_LEN[i]) &&
                word[j] != stt_pkg::KW_TEXT[i][8*(int'(stt_pkg::KW_LEN[i])-1-j) +: 8]) begin
               hit[i] = 1'b0;
            end
         end
      end
   end

   always_comb begin
      kind = stt_pkg::K_IDENT;
      for (int i = 0; i < stt_pkg::KW_COUNT; i++) begin
         if (hit[i]) begin
            kind = stt_pkg::K_KW0 + stt_pkg::KIND_W'(i);
         end
      end
   end

endmodule

FILE: rtl/core/stt_outq.sv
// Two-entry result queue; takes up to two results per cycle in order.
// No package dependencies.
module stt_outq #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_a,
   input  logic [WIDTH-1:0] data_a,
   input  logic             push_b,
   input  logic [WIDTH-1:0] data_b,
   input  logic             pop,
   output logic [1:0]       count,
   output logic [WIDTH-1:0] head
);

   logic [WIDTH-1:0] ent_ff [2];
   logic [WIDTH-1:0] ent_in [2];
   logic [1:0]       cnt_ff, cnt_in;

   always_comb begin
      ent_in = ent_ff;
      cnt_in = cnt_ff;
      if (pop) begin
         ent_in[0] = ent_ff[1];
         cnt_in    = cnt_ff - 2'd1;
      end
      // append in arrival order
      if (push_a) begin
         ent_in[cnt_in[0]] = data_a;
         cnt_in            = cnt_in + 2'd1;
      end
      if (push_b) begin
         ent_in[cnt_in[0]] = data_b;
         cnt_in            = cnt_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      ent_ff <= ent_in;
   end

   assign count = cnt_ff;
   assign head  = ent_ff[0];

endmodule

FILE: rtl/core/stt_checker.sv
// Port-level checks for source_text_tokenizer_unit, bound to the top level.
// Depends on stt_pkg.
module stt_checker #(
   parameter int POSITION_BITS = 16
) (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [6:0]               rsp_token_kind,
   input logic [POSITION_BITS-1:0] rsp_first_line,
   input logic [20:0]              rsp_text_length,
   input logic                     rsp_last_of_run
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before it was taken");

   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while the result queue is stalled");

   a_end_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_kind == stt_pkg::K_END |-> rsp_last_of_run &&
      rsp_text_length == '0)
      else $error("end marker not last or has a length");

   a_line_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_first_line != '0)
      else $error("result with line zero");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending right after reset");

endmodule

bind source_text_tokenizer_unit stt_checker #(.POSITION_BITS(POSITION_BITS)) u_stt_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_token_kind  (rsp_token_kind),
   .rsp_first_line  (rsp_first_line),
   .rsp_text_length (rsp_text_length),
   .rsp_last_of_run (rsp_last_of_run)
);
